>>> rtl/core/ypr_pkg.sv
package ypr_pkg;

	localparam int ANGLE_TURN    = 92160;
	localparam int ANGLE_QUARTER = 23040;
	localparam int ANGLE_WIDTH   = 18;

	// Angle remainder to radians (Q30): pi*2^32/184320 split into quotient and remainder
	localparam int RAD_QUO      = 73204;
	localparam int RAD_REM      = 76425;
	localparam int RAD_HALF     = 92160;
	localparam int DIV45_RECIP  = 745655;
	localparam int DIV45_SHIFT  = 25;
	localparam int RAD_POW2     = 12;

	localparam int CORDIC_GAIN  = 652032874;
	localparam int ATAN_ENTRIES = 24;
	localparam int TRIG_ONE     = 30;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	function automatic logic signed [31:0] atan_q30(input int idx);
		logic signed [31:0] v;
		unique case (idx)
			0: v = 32'sd843314857;
			1: v = 32'sd497837829;
			2: v = 32'sd263043837;
			3: v = 32'sd133525159;
			4: v = 32'sd67021687;
			5: v = 32'sd33543516;
			6: v = 32'sd16775851;
			7: v = 32'sd8388437;
			8: v = 32'sd4194283;
			9: v = 32'sd2097149;
			10: v = 32'sd1048576;
			11: v = 32'sd524288;
			12: v = 32'sd262144;
			13: v = 32'sd131072;
			14: v = 32'sd65536;
			15: v = 32'sd32768;
			16: v = 32'sd16384;
			17: v = 32'sd8192;
			18: v = 32'sd4096;
			19: v = 32'sd2048;
			20: v = 32'sd1024;
			21: v = 32'sd512;
			22: v = 32'sd256;
			23: v = 32'sd128;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/core/ypr_in_if.sv
interface ypr_in_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] vec_x;
	logic signed [COORD_WIDTH-1:0] vec_y;
	logic signed [COORD_WIDTH-1:0] vec_z;
	logic signed [17:0]            yaw_angle;
	logic signed [17:0]            pitch_angle;

	modport source (output valid, vec_x, vec_y, vec_z, yaw_angle, pitch_angle, input ready);
	modport sink (input valid, vec_x, vec_y, vec_z, yaw_angle, pitch_angle, output ready);
endinterface

>>> rtl/core/ypr_out_if.sv
interface ypr_out_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] rot_x;
	logic signed [COORD_WIDTH-1:0] rot_y;
	logic signed [COORD_WIDTH-1:0] rot_z;
	logic                          saturated;

	modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
	modport sink (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

>>> rtl/core/yaw_pitch_vector_rotation.sv
// Rotates a signed fixed-point vector about X by pitch, then about Y by yaw (angles in
// 1/256 degree, any 18-bit value, reduced modulo one turn); outputs saturate and flag it.
// Fully pipelined: one item per cycle unless the output is held. The pipeline is made of
// the angle reduction, the CORDIC micro-rotation chain and two multiply-and-round
// stages. When the output is held the whole pipeline holds with it.
module yaw_pitch_vector_rotation #(
	parameter int COORD_WIDTH = 32,
	parameter int TRIG_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	ypr_in_if.sink    req,
	ypr_out_if.source rsp
);
	localparam int N         = (TRIG_STAGES < ypr_pkg::ATAN_ENTRIES) ? TRIG_STAGES
		: ypr_pkg::ATAN_ENTRIES;
	localparam int LAT       = N + 6;
	localparam int TRIG_FRAC = ((62 - COORD_WIDTH) < 30) ? (62 - COORD_WIDTH) : 30;
	localparam int TW        = TRIG_FRAC + 2;

	logic                          adv;
	logic                          pv, yv, rv;
	logic signed [TW-1:0]          cp, sp, cw, sw;
	logic signed [COORD_WIDTH-1:0] vx_q [LAT];
	logic signed [COORD_WIDTH-1:0] vy_q [LAT];
	logic signed [COORD_WIDTH-1:0] vz_q [LAT];

	// advance whenever the output register is empty or being taken
	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	ypr_trig #(.COORD_WIDTH(COORD_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_pitch (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.vld_in(req.valid), .angle(req.pitch_angle),
		.vld_out(pv), .cos_o(cp), .sin_o(sp)
	);

	ypr_trig #(.COORD_WIDTH(COORD_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_yaw (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.vld_in(req.valid), .angle(req.yaw_angle),
		.vld_out(yv), .cos_o(cw), .sin_o(sw)
	);

	// hold the vector alongside the angle pipelines
	always_ff @(posedge clk) begin
		if (adv) begin
			vx_q[0] <= req.vec_x;
			vy_q[0] <= req.vec_y;
			vz_q[0] <= req.vec_z;
			for (int k = 1; k < LAT; k++) begin
				vx_q[k] <= vx_q[k-1];
				vy_q[k] <= vy_q[k-1];
				vz_q[k] <= vz_q[k-1];
			end
		end
	end

	ypr_rot #(.COORD_WIDTH(COORD_WIDTH)) u_rot (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.vld_in(pv & yv),
		.x(vx_q[LAT-1]), .y(vy_q[LAT-1]), .z(vz_q[LAT-1]),
		.cp(cp), .sp(sp), .cw(cw), .sw(sw),
		.vld_out(rv),
		.rx(rsp.rot_x), .ry(rsp.rot_y), .rz(rsp.rot_z), .sat(rsp.saturated)
	);

	assign rsp.valid = rv;
endmodule

>>> rtl/core/ypr_trig.sv
module ypr_trig #(
	parameter int COORD_WIDTH = 32,
	parameter int TRIG_STAGES = 16,
	localparam int TRIG_FRAC  = ((62 - COORD_WIDTH) < 30) ? (62 - COORD_WIDTH) : 30,
	localparam int TW         = TRIG_FRAC + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 vld_in,
	input  logic signed [17:0]   angle,
	output logic                 vld_out,
	output logic signed [TW-1:0] cos_o,
	output logic signed [TW-1:0] sin_o
);
	localparam int N  = (TRIG_STAGES < ypr_pkg::ATAN_ENTRIES) ? TRIG_STAGES
		: ypr_pkg::ATAN_ENTRIES;
	localparam int SH = ypr_pkg::TRIG_ONE - TRIG_FRAC;
	localparam logic signed [32:0] RND = (SH > 0) ? (33'sd1 <<< ((SH > 0) ? SH - 1 : 0))
		: 33'sd0;

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s6;
	logic [16:0]         m_s1;
	ypr_pkg::quad_t      q_s2, q_s3, q_s4;
	logic [14:0]         r_s2;
	logic [31:0]         mrc_s3, rqc_s3, rqc_s4;
	logic [39:0]         prod_s4;
	logic                cv_q [N+1];
	ypr_pkg::quad_t      cq_q [N+1];
	logic signed [31:0]  cx_q [N+1];
	logic signed [31:0]  cy_q [N+1];
	logic signed [31:0]  cz_q [N+1];
	logic signed [TW-1:0] cos_s6, sin_s6;

	logic signed [19:0] a_ext, a_p1, a_p2, a_m1, m_c;
	ypr_pkg::quad_t     q_c;
	logic [16:0]        r_c;
	logic signed [31:0] c30, s30;
	logic signed [32:0] c_rnd, s_rnd;

	// reduce modulo one turn: at most two turns away
	always_comb begin
		a_ext = {{2{angle[17]}}, angle};
		a_p1  = a_ext + 20'(ypr_pkg::ANGLE_TURN);
		a_p2  = a_ext + 20'(2 * ypr_pkg::ANGLE_TURN);
		a_m1  = a_ext - 20'(ypr_pkg::ANGLE_TURN);
		priority if (a_ext < 0) begin
			m_c = (a_p1 < 0) ? a_p2 : a_p1;
		end else if (a_ext >= 20'(ypr_pkg::ANGLE_TURN)) begin
			m_c = a_m1;
		end else begin
			m_c = a_ext;
		end
	end

	always_comb begin
		priority if (m_s1 < 17'(ypr_pkg::ANGLE_QUARTER)) begin
			q_c = ypr_pkg::QUAD_0;
			r_c = m_s1;
		end else if (m_s1 < 17'(2 * ypr_pkg::ANGLE_QUARTER)) begin
			q_c = ypr_pkg::QUAD_1;
			r_c = m_s1 - 17'(ypr_pkg::ANGLE_QUARTER);
		end else if (m_s1 < 17'(3 * ypr_pkg::ANGLE_QUARTER)) begin
			q_c = ypr_pkg::QUAD_2;
			r_c = m_s1 - 17'(2 * ypr_pkg::ANGLE_QUARTER);
		end else begin
			q_c = ypr_pkg::QUAD_3;
			r_c = m_s1 - 17'(3 * ypr_pkg::ANGLE_QUARTER);
		end
	end

	always_comb begin
		unique case (cq_q[N])
			ypr_pkg::QUAD_0: begin c30 = cx_q[N];  s30 = cy_q[N];  end
			ypr_pkg::QUAD_1: begin c30 = -cy_q[N]; s30 = cx_q[N];  end
			ypr_pkg::QUAD_2: begin c30 = -cx_q[N]; s30 = -cy_q[N]; end
			default:         begin c30 = cy_q[N];  s30 = -cx_q[N]; end
		endcase
		c_rnd = (33'(c30) + RND) >>> SH;
		s_rnd = (33'(s30) + RND) >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s6 <= cv_q[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1    <= m_c[16:0];
			q_s2    <= q_c;
			r_s2    <= r_c[14:0];
			q_s3    <= q_s2;
			mrc_s3  <= 32'(r_s2) * 32'(ypr_pkg::RAD_REM) + 32'(ypr_pkg::RAD_HALF);
			rqc_s3  <= 32'(r_s2) * 32'(ypr_pkg::RAD_QUO);
			q_s4    <= q_s3;
			rqc_s4  <= rqc_s3;
			prod_s4 <= 40'(mrc_s3[30:ypr_pkg::RAD_POW2]) * 40'(ypr_pkg::DIV45_RECIP);
			cos_s6  <= c_rnd[TW-1:0];
			sin_s6  <= s_rnd[TW-1:0];
		end
	end

	// stage 5 seeds the rotation, then one CORDIC micro-rotation per register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q[0] <= 1'b0;
		end else if (adv) begin
			cv_q[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cq_q[0] <= q_s4;
			cx_q[0] <= 32'(ypr_pkg::CORDIC_GAIN);
			cy_q[0] <= 32'sd0;
			cz_q[0] <= $signed(rqc_s4 + 32'(prod_s4[39:ypr_pkg::DIV45_SHIFT]));
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_q[k+1] <= 1'b0;
			end else if (adv) begin
				cv_q[k+1] <= cv_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cq_q[k+1] <= cq_q[k];
				if (cz_q[k] >= 0) begin
					cx_q[k+1] <= cx_q[k] - (cy_q[k] >>> k);
					cy_q[k+1] <= cy_q[k] + (cx_q[k] >>> k);
					cz_q[k+1] <= cz_q[k] - ypr_pkg::atan_q30(k);
				end else begin
					cx_q[k+1] <= cx_q[k] + (cy_q[k] >>> k);
					cy_q[k+1] <= cy_q[k] - (cx_q[k] >>> k);
					cz_q[k+1] <= cz_q[k] + ypr_pkg::atan_q30(k);
				end
			end
		end
	end

	assign vld_out = vld_s6;
	assign cos_o   = cos_s6;
	assign sin_o   = sin_s6;
endmodule

>>> rtl/core/ypr_rot.sv
module ypr_rot #(
	parameter int COORD_WIDTH = 32,
	localparam int TRIG_FRAC  = ((62 - COORD_WIDTH) < 30) ? (62 - COORD_WIDTH) : 30,
	localparam int TW         = TRIG_FRAC + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          vld_in,
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic signed [COORD_WIDTH-1:0] y,
	input  logic signed [COORD_WIDTH-1:0] z,
	input  logic signed [TW-1:0]          cp,
	input  logic signed [TW-1:0]          sp,
	input  logic signed [TW-1:0]          cw,
	input  logic signed [TW-1:0]          sw,
	output logic                          vld_out,
	output logic signed [COORD_WIDTH-1:0] rx,
	output logic signed [COORD_WIDTH-1:0] ry,
	output logic signed [COORD_WIDTH-1:0] rz,
	output logic                          sat
);
	localparam int CW = COORD_WIDTH;
	localparam int QW = CW + TW + 1;
	localparam int SW = QW + 2;
	localparam int VW = SW - TRIG_FRAC;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [CW-1:0] HI = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] LO = {1'b1, {(CW-1){1'b0}}};

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [QW-1:0] yc_s1, zs_s1, ys_s1, zc_s1;
	logic signed [CW-1:0] x_s1, x_s2;
	logic signed [TW-1:0] cw_s1, sw_s1, cw_s2, sw_s2;
	logic signed [VW-1:0] y1_s2, y1_s3;
	logic signed [CW:0]   z1_s2;
	logic signed [QW-1:0] xc_s3, zs_s3, zc_s3, xs_s3;
	logic signed [CW-1:0] rx_s4, ry_s4, rz_s4;
	logic                 sat_s4;

	logic signed [SW-1:0] y1_sum, z1_sum, x2_sum, z2_sum;
	logic signed [VW-1:0] x2_v, z2_v;
	logic                 ox, oy, oz;

	function automatic logic ovf(input logic signed [VW-1:0] v);
		return !((&v[VW-1:CW-1]) || !(|v[VW-1:CW-1]));
	endfunction

	function automatic logic signed [CW-1:0] clamp(input logic signed [VW-1:0] v);
		logic signed [CW-1:0] r;
		priority if (!ovf(v)) begin
			r = v[CW-1:0];
		end else if (v[VW-1]) begin
			r = LO;
		end else begin
			r = HI;
		end
		return r;
	endfunction

	always_comb begin
		y1_sum = SW'(yc_s1) - SW'(zs_s1) + HALF;
		z1_sum = SW'(ys_s1) + SW'(zc_s1) + HALF;
		x2_sum = SW'(xc_s3) + SW'(zs_s3) + HALF;
		z2_sum = SW'(zc_s3) - SW'(xs_s3) + HALF;
		x2_v   = $signed(x2_sum[SW-1:TRIG_FRAC]);
		z2_v   = $signed(z2_sum[SW-1:TRIG_FRAC]);
		ox     = ovf(x2_v);
		oy     = ovf(y1_s3);
		oz     = ovf(z2_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// pitch: rotate about X
			yc_s1 <= QW'(y) * QW'(cp);
			zs_s1 <= QW'(z) * QW'(sp);
			ys_s1 <= QW'(y) * QW'(sp);
			zc_s1 <= QW'(z) * QW'(cp);
			x_s1  <= x;
			cw_s1 <= cw;
			sw_s1 <= sw;

			y1_s2 <= $signed(y1_sum[SW-1:TRIG_FRAC]);
			z1_s2 <= $signed(z1_sum[TRIG_FRAC+CW:TRIG_FRAC]);
			x_s2  <= x_s1;
			cw_s2 <= cw_s1;
			sw_s2 <= sw_s1;

			// yaw: rotate about Y with the new z
			xc_s3 <= QW'(x_s2) * QW'(cw_s2);
			zs_s3 <= QW'(z1_s2) * QW'(sw_s2);
			zc_s3 <= QW'(z1_s2) * QW'(cw_s2);
			xs_s3 <= QW'(x_s2) * QW'(sw_s2);
			y1_s3 <= y1_s2;

			rx_s4  <= clamp(x2_v);
			ry_s4  <= clamp(y1_s3);
			rz_s4  <= clamp(z2_v);
			sat_s4 <= ox | oy | oz;
		end
	end

	assign vld_out = vld_s4;
	assign rx      = rx_s4;
	assign ry      = ry_s4;
	assign rz      = rz_s4;
	assign sat     = sat_s4;
endmodule

>>> sim/tb_yaw_pitch_vector_rotation.sv
module tb_yaw_pitch_vector_rotation;

	localparam int CW = 32;
	localparam int STAGES = 16;
	localparam int LATENCY = 26;
	localparam int TFRAC = (62 - CW) < 30 ? (62 - CW) : 30;
	localparam longint PI_Q32 = 64'd13493037705;
	localparam longint RAD_DIV = 184320;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic signed [17:0]   yaw;
		logic signed [17:0]   pitch;
	} vec_item_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 sat;
	} rot_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int error_count = 0;
	int hold_cycles = 0;
	int stall_cycles = 0;
	bit burst_mode = 1'b0;
	rot_item_t expected_rots[$];

	ypr_in_if #(.COORD_WIDTH(CW)) req ();
	ypr_out_if #(.COORD_WIDTH(CW)) rsp ();

	yaw_pitch_vector_rotation #(.COORD_WIDTH(CW), .TRIG_STAGES(STAGES)) u_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#400000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	// cos and sin of an angle in 1/256 degree, at TFRAC fraction bits
	function automatic void sin_cos(logic signed [17:0] ang, output longint c,
			output longint s);
		longint m, r, zz, xx, yy, dx, dy;
		ypr_pkg::quad_t q;
		m = longint'(ang) % ypr_pkg::ANGLE_TURN;
		if (m < 0) m += ypr_pkg::ANGLE_TURN;
		q = ypr_pkg::quad_t'(m / ypr_pkg::ANGLE_QUARTER);
		r = m % ypr_pkg::ANGLE_QUARTER;
		zz = (r * PI_Q32 + RAD_DIV / 2) / RAD_DIV;
		xx = ypr_pkg::CORDIC_GAIN;
		yy = 0;
		for (int i = 0; i < STAGES && i < ypr_pkg::ATAN_ENTRIES; i++) begin
			dx = fshr(yy, i);
			dy = fshr(xx, i);
			if (zz >= 0) begin
				xx -= dx; yy += dy; zz -= ypr_pkg::atan_q30(i);
			end else begin
				xx += dx; yy -= dy; zz += ypr_pkg::atan_q30(i);
			end
		end
		case (q)
			ypr_pkg::QUAD_0: begin c = xx; s = yy; end
			ypr_pkg::QUAD_1: begin c = -yy; s = xx; end
			ypr_pkg::QUAD_2: begin c = -xx; s = -yy; end
			default: begin c = yy; s = -xx; end
		endcase
		if (TFRAC < 30) begin
			c = fshr(c + (64'sd1 <<< (29 - TFRAC)), 30 - TFRAC);
			s = fshr(s + (64'sd1 <<< (29 - TFRAC)), 30 - TFRAC);
		end
	endfunction

	function automatic longint round_prod(longint p);
		return fshr(p + (64'sd1 <<< (TFRAC - 1)), TFRAC);
	endfunction

	function automatic logic signed [CW-1:0] clamp(longint v, inout logic sat);
		longint hi, lo;
		hi = (64'sd1 <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			sat = 1'b1;
			return hi[CW-1:0];
		end
		if (v < lo) begin
			sat = 1'b1;
			return lo[CW-1:0];
		end
		return v[CW-1:0];
	endfunction

	function automatic rot_item_t rotate_vector(vec_item_t v);
		longint cp, sp, cw, sw, y1, z1, x2, z2;
		rot_item_t r;
		logic sat;
		sat = 1'b0;
		sin_cos(v.pitch, cp, sp);
		sin_cos(v.yaw, cw, sw);
		y1 = round_prod(longint'(v.y) * cp - longint'(v.z) * sp);
		z1 = round_prod(longint'(v.y) * sp + longint'(v.z) * cp);
		x2 = round_prod(longint'(v.x) * cw + z1 * sw);
		z2 = round_prod(z1 * cw - longint'(v.x) * sw);
		r.x = clamp(x2, sat);
		r.y = clamp(y1, sat);
		r.z = clamp(z2, sat);
		r.sat = sat;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 40) return 0;
		if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// keep valid up between back-to-back items, drop it only before a gap
	task automatic send_vector(vec_item_t v);
		int gap;
		gap = burst_mode ? 0 : gap_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.vec_x <= v.x;
		req.vec_y <= v.y;
		req.vec_z <= v.z;
		req.yaw_angle <= v.yaw;
		req.pitch_angle <= v.pitch;
		do @(posedge clk); while (!req.ready);
		expected_rots.push_back(rotate_vector(v));
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			1: return $signed(32'($urandom_range(0, 1 << 20))) - (1 <<< 19);
			default: return $urandom;
		endcase
	endfunction

	function automatic vec_item_t rand_vector();
		vec_item_t v;
		v.x = rand_coord();
		v.y = rand_coord();
		v.z = rand_coord();
		v.yaw = $urandom_range(0, 3) == 0 ? 18'($urandom) : 18'($urandom_range(0, 184320) - 92160);
		v.pitch = $urandom_range(0, 3) == 0 ? 18'($urandom) :
			18'($urandom_range(0, 184320) - 92160);
		return v;
	endfunction

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (expected_rots.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		logic signed [17:0] angs[10] = '{0, 23040, 46080, 69120, 92160, -92160, 11520,
			-1, 18'sh1ffff, 18'sh20000};
		vec_item_t v;
		foreach (angs[i]) begin
			v = '{x: 32'sh00010000, y: 32'sh00020000, z: -32'sh00030000,
				yaw: angs[i], pitch: angs[(i + 3) % 10]};
			send_vector(v);
		end
		send_vector('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 11520, 11520});
		send_vector('{32'sh80000000, 32'sh80000000, 32'sh80000000, 11520, 11520});
		send_vector('{32'sh80000000, 32'sh7fffffff, 32'sh80000000, -11520, 34560});
		send_vector('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0});
		send_vector('{32'sh0, 32'sh0, 32'sh0, 18'sh1ffff, 18'sh20000});
		send_vector('{-32'sd1, -32'sd1, -32'sd1, 5760, -5760});
		wait_drained();
	endtask

	task automatic test_random(int count);
		repeat (count) send_vector(rand_vector());
	endtask

	task automatic test_backpressure();
		hold_cycles = 200;
		burst_mode = 1'b1;
		repeat (60) send_vector(rand_vector());
		burst_mode = 1'b0;
		wait_drained();
	endtask

	// sink side: random stalls, a few long ones, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else if (stall_cycles > 0) begin
			stall_cycles <= stall_cycles - 1;
			rsp.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 70) begin
			rsp.ready <= 1'b1;
		end else begin
			rsp.ready <= 1'b0;
			if ($urandom_range(0, 19) == 0) stall_cycles <= $urandom_range(10, 40);
		end
	end

	always @(posedge clk) begin
		rot_item_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rots.size() == 0) begin
				report_mismatch("unexpected item", 0, 0);
			end else begin
				want = expected_rots.pop_front();
				if (rsp.rot_x !== want.x) report_mismatch("rot_x", rsp.rot_x, want.x);
				if (rsp.rot_y !== want.y) report_mismatch("rot_y", rsp.rot_y, want.y);
				if (rsp.rot_z !== want.z) report_mismatch("rot_z", rsp.rot_z, want.z);
				if (rsp.saturated !== want.sat)
					report_mismatch("saturated", rsp.saturated, want.sat);
			end
		end
	end

	initial begin
		int guard;
		req.valid = 1'b0;
		req.vec_x = '0;
		req.vec_y = '0;
		req.vec_z = '0;
		req.yaw_angle = '0;
		req.pitch_angle = '0;
		rsp.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500);
		wait_drained();
		test_backpressure();
		test_random(670);
		req.valid <= 1'b0;
		guard = 0;
		while (expected_rots.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY * 4) @(posedge clk);
		if (error_count == 0 && expected_rots.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

>>> sim.f
rtl/core/ypr_pkg.sv
rtl/core/ypr_in_if.sv
rtl/core/ypr_out_if.sv
rtl/core/ypr_trig.sv
rtl/core/ypr_rot.sv
rtl/core/yaw_pitch_vector_rotation.sv
sim/tb_yaw_pitch_vector_rotation.sv
